/* design/rcsb_pkg.sv */
package rcsb_pkg;

    // Frame buffer geometry
    localparam int MAX_WIDTH  = 640;
    localparam int MAX_HEIGHT = 480;
    localparam int FB_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(FB_DEPTH);

    // Field widths
    localparam int PIX_W = 24;
    localparam int CRD_W = 12;          // signed coordinate fields
    localparam int SUM_W = CRD_W + 1;   // coordinate plus rectangle offset
    localparam int CNT_W = CRD_W - 1;   // rectangle offset counters
    localparam int IW_W  = 10;          // image_width register
    localparam int IH_W  = 9;           // image_height register
    localparam int CFG_W = 10;          // widest register

    // Register reset values
    localparam logic [IW_W-1:0] RST_IMG_WIDTH  = 10'd640;
    localparam logic [IH_W-1:0] RST_IMG_HEIGHT = 9'd480;

    // Register indexes
    localparam logic CFG_IMG_WIDTH  = 1'b0;
    localparam logic CFG_IMG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_COPY  = 2'd2,
        OP_SWAP  = 2'd3
    } op_t;

    typedef enum logic {
        ST_DONE  = 1'b0,
        ST_RANGE = 1'b1
    } status_t;

    // Memory access from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [PIX_W-1:0]  wr_data;
    } mem_req_t;

    // Finished result handed to the output register
    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [PIX_W-1:0] pixel;
    } res_t;

    // Coordinate lies in [0, lim)
    function automatic logic in_range(input logic [SUM_W-1:0] c, input logic [IW_W-1:0] lim);
        return !c[SUM_W-1] && (c[SUM_W-2:0] < CRD_W'(lim));
    endfunction

    // Linear address y * w + x of an in-range pixel
    function automatic logic [ADDR_W-1:0] pix_addr(input logic [SUM_W-1:0] x,
                                                   input logic [SUM_W-1:0] y,
                                                   input logic [IW_W-1:0]  w);
        logic [ADDR_W-1:0] prod;
        prod = ADDR_W'(y[IH_W-1:0]) * ADDR_W'(w);
        return prod + ADDR_W'(x[IW_W-1:0]);
    endfunction

endpackage

/* design/rcsb_fb_mem.sv */
module rcsb_fb_mem
    import rcsb_pkg::*;
(
    input  logic             clk,
    input  mem_req_t         req,
    output logic [PIX_W-1:0] rd_data
);

    logic [PIX_W-1:0] mem [FB_DEPTH];

    // One write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

/* design/rcsb_seq.sv */
module rcsb_seq
    import rcsb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    busy,
    input  op_t                     operation,
    input  logic signed [CRD_W-1:0] src_x,
    input  logic signed [CRD_W-1:0] src_y,
    input  logic signed [CRD_W-1:0] rect_width,
    input  logic signed [CRD_W-1:0] rect_height,
    input  logic signed [CRD_W-1:0] dst_x,
    input  logic signed [CRD_W-1:0] dst_y,
    input  logic [PIX_W-1:0]        pixel_in,
    input  logic [IW_W-1:0]         img_w,
    input  logic [IH_W-1:0]         img_h,
    output mem_req_t                mem_req,
    input  logic [PIX_W-1:0]        mem_rd_data,
    output res_t                    res,
    input  logic                    res_take
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_WR_PIX,
        S_RD_PIX,
        S_CAPT,
        S_RD_SRC,
        S_WR_DST,
        S_RD_DST,
        S_SWP_DST,
        S_SWP_SRC,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic signed [CRD_W-1:0] sx0_reg, sx0_next, sy0_reg, sy0_next;
    logic signed [CRD_W-1:0] dx0_reg, dx0_next, dy0_reg, dy0_next;
    logic [PIX_W-1:0]        pin_reg, pin_next;
    logic [CNT_W-1:0]        rw_m1_reg, rw_m1_next, rh_m1_reg, rh_m1_next;
    logic [CNT_W-1:0]        xi_reg, xi_next, yi_reg, yi_next;
    logic [ADDR_W-1:0]       sa_reg, sa_next, da_reg, da_next;
    logic [PIX_W-1:0]        hold_reg, hold_next;
    status_t                 status_reg, status_next;
    logic [PIX_W-1:0]        pixel_reg, pixel_next;

    logic [CRD_W-1:0] rw_dec, rh_dec;
    logic             rect_empty, is_blit;
    logic [SUM_W-1:0] sx, sy, dx, dy;
    logic             src_ok, dst_ok;
    logic             y_last, x_last;

    // Request decode
    assign rw_dec     = rect_width - CRD_W'(1);
    assign rh_dec     = rect_height - CRD_W'(1);
    assign rect_empty = rect_width[CRD_W-1] || (rect_width == '0)
                     || rect_height[CRD_W-1] || (rect_height == '0);
    assign is_blit    = (op_reg == OP_COPY) || (op_reg == OP_SWAP);

    // Current pixel coordinates and bounds check
    assign sx = {sx0_reg[CRD_W-1], sx0_reg} + SUM_W'(xi_reg);
    assign sy = {sy0_reg[CRD_W-1], sy0_reg} + SUM_W'(yi_reg);
    assign dx = {dx0_reg[CRD_W-1], dx0_reg} + SUM_W'(xi_reg);
    assign dy = {dy0_reg[CRD_W-1], dy0_reg} + SUM_W'(yi_reg);

    assign src_ok = in_range(sx, img_w) && in_range(sy, IW_W'(img_h));
    assign dst_ok = in_range(dx, img_w) && in_range(dy, IW_W'(img_h));

    assign y_last = (yi_reg == rh_m1_reg);
    assign x_last = (xi_reg == rw_m1_reg);

    assign busy = (state_reg != S_IDLE);
    assign res  = '{valid: (state_reg == S_DONE), status: status_reg, pixel: pixel_reg};

    // Next state and memory requests
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        sx0_next    = sx0_reg;
        sy0_next    = sy0_reg;
        dx0_next    = dx0_reg;
        dy0_next    = dy0_reg;
        pin_next    = pin_reg;
        rw_m1_next  = rw_m1_reg;
        rh_m1_next  = rh_m1_reg;
        xi_next     = xi_reg;
        yi_next     = yi_reg;
        sa_next     = sa_reg;
        da_next     = da_reg;
        hold_next   = hold_reg;
        status_next = status_reg;
        pixel_next  = pixel_reg;
        mem_req     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = operation;
                    sx0_next    = src_x;
                    sy0_next    = src_y;
                    dx0_next    = dst_x;
                    dy0_next    = dst_y;
                    pin_next    = pixel_in;
                    rw_m1_next  = rw_dec[CNT_W-1:0];
                    rh_m1_next  = rh_dec[CNT_W-1:0];
                    xi_next     = '0;
                    yi_next     = '0;
                    status_next = ST_DONE;
                    pixel_next  = '0;
                    if ((operation inside {OP_COPY, OP_SWAP}) && rect_empty)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                sa_next = pix_addr(sx, sy, img_w);
                da_next = pix_addr(dx, dy, img_w);
                if (!dst_ok || (is_blit && !src_ok))
                begin
                    status_next = ST_RANGE;
                    state_next  = S_DONE;
                end
                else
                begin
                    case (op_reg)
                        OP_WRITE: state_next = S_WR_PIX;
                        OP_READ:  state_next = S_RD_PIX;
                        default:  state_next = S_RD_SRC;
                    endcase
                end
            end

            S_WR_PIX:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = da_reg;
                mem_req.wr_data = pin_reg;
                state_next      = S_DONE;
            end

            S_RD_PIX:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = da_reg;
                state_next      = S_CAPT;
            end

            S_CAPT:
            begin
                pixel_next = mem_rd_data;
                state_next = S_DONE;
            end

            S_RD_SRC:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = sa_reg;
                state_next      = (op_reg == OP_SWAP) ? S_RD_DST : S_WR_DST;
            end

            // swap: source value arrives, fetch destination
            S_RD_DST:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = da_reg;
                hold_next       = mem_rd_data;
                state_next      = S_SWP_DST;
            end

            S_SWP_DST:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = da_reg;
                mem_req.wr_data = hold_reg;
                hold_next       = mem_rd_data;
                state_next      = S_SWP_SRC;
            end

            S_WR_DST, S_SWP_SRC:
            begin
                mem_req.wr_en = 1'b1;
                if (state_reg == S_WR_DST)
                begin
                    mem_req.wr_addr = da_reg;
                    mem_req.wr_data = mem_rd_data;
                end
                else
                begin
                    mem_req.wr_addr = sa_reg;
                    mem_req.wr_data = hold_reg;
                end
                // column-major walk: y inner, x outer
                if (!y_last)
                begin
                    yi_next    = yi_reg + CNT_W'(1);
                    state_next = S_CHECK;
                end
                else if (!x_last)
                begin
                    yi_next    = '0;
                    xi_next    = xi_reg + CNT_W'(1);
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_WRITE;
            sx0_reg    <= '0;
            sy0_reg    <= '0;
            dx0_reg    <= '0;
            dy0_reg    <= '0;
            pin_reg    <= '0;
            rw_m1_reg  <= '0;
            rh_m1_reg  <= '0;
            xi_reg     <= '0;
            yi_reg     <= '0;
            sa_reg     <= '0;
            da_reg     <= '0;
            hold_reg   <= '0;
            status_reg <= ST_DONE;
            pixel_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            sx0_reg    <= sx0_next;
            sy0_reg    <= sy0_next;
            dx0_reg    <= dx0_next;
            dy0_reg    <= dy0_next;
            pin_reg    <= pin_next;
            rw_m1_reg  <= rw_m1_next;
            rh_m1_reg  <= rh_m1_next;
            xi_reg     <= xi_next;
            yi_reg     <= yi_next;
            sa_reg     <= sa_next;
            da_reg     <= da_next;
            hold_reg   <= hold_next;
            status_reg <= status_next;
            pixel_reg  <= pixel_next;
        end
    end

endmodule

/* design/rect_copy_swap_blitter_top.sv */
// Rectangle copy / swap blitter over a 640 x 480 RGB frame buffer.
//
// Input channel (in_valid / in_stall) carries one request: write pixel,
// read pixel, copy rectangle or swap rectangle. Output channel
// (out_valid / out_stall) returns exactly one result per request:
// status (0 done, 1 coordinate out of range) and pixel_out (read data,
// zero otherwise). image_width / image_height are written through
// cfg_we / cfg_index / cfg_data; the user must do so only while no
// request is in flight, and the block does not enforce this.
//
// One sequencer around a single frame buffer RAM (registered read)
// handles requests one at a time: a bounds check, then RAM reads and writes.
// It takes no new request until the last result has left the sequencer.
// A finished result sits in the output register, so the next request is
// taken while it waits. If the receiver stalls and a second result is
// ready, the sequencer holds it and stalls the input.
// Reset clears control and restores 640 x 480; frame buffer contents
// are undefined until written.
module rect_copy_swap_blitter_top
    import rcsb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              operation,
    input  logic signed [CRD_W-1:0] src_x,
    input  logic signed [CRD_W-1:0] src_y,
    input  logic signed [CRD_W-1:0] rect_width,
    input  logic signed [CRD_W-1:0] rect_height,
    input  logic signed [CRD_W-1:0] dst_x,
    input  logic signed [CRD_W-1:0] dst_y,
    input  logic [PIX_W-1:0]        pixel_in,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    status,
    output logic [PIX_W-1:0]        pixel_out,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    logic [IW_W-1:0]  img_width_reg, img_w_eff;
    logic [IH_W-1:0]  img_height_reg, img_h_eff;
    logic             out_valid_reg;
    status_t          status_reg;
    logic [PIX_W-1:0] pixel_out_reg;
    mem_req_t         mem_req;
    logic [PIX_W-1:0] mem_rd_data;
    res_t             res;
    logic             res_take;
    logic             busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_width_reg  <= RST_IMG_WIDTH;
            img_height_reg <= RST_IMG_HEIGHT;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_IMG_WIDTH)
            begin
                img_width_reg <= cfg_data;
            end
            else
            begin
                img_height_reg <= cfg_data[IH_W-1:0];
            end
        end
    end

    // Clamp to the buffer size
    assign img_w_eff = (32'(img_width_reg) > MAX_WIDTH) ? IW_W'(MAX_WIDTH) : img_width_reg;
    assign img_h_eff = (32'(img_height_reg) > MAX_HEIGHT) ? IH_W'(MAX_HEIGHT) : img_height_reg;

    rcsb_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .busy        (busy),
        .operation   (op_t'(operation)),
        .src_x       (src_x),
        .src_y       (src_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .dst_x       (dst_x),
        .dst_y       (dst_y),
        .pixel_in    (pixel_in),
        .img_w       (img_w_eff),
        .img_h       (img_h_eff),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .res         (res),
        .res_take    (res_take)
    );

    rcsb_fb_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    assign in_stall = busy;

    // Output register: loads when empty or being drained
    assign res_take = res.valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= ST_DONE;
            pixel_out_reg <= '0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
            status_reg    <= res.status;
            pixel_out_reg <= res.pixel;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign pixel_out = pixel_out_reg;

endmodule

/* design/rcsb_checker.sv */
module rcsb_checker
    import rcsb_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic             status,
    input logic [PIX_W-1:0] pixel_out
);

    logic [1:0] pend_reg;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // Requests accepted but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(in_acc) - 2'(out_acc);
        end
    end

    // A range error never carries pixel data
    a_err_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (pixel_out == '0))
        else $error("range error with nonzero pixel_out");

    // No result without an outstanding request
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != 2'd0))
        else $error("result without request");

    // At most one request in the sequencer plus one in the output register
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (pend_reg <= 2'd1))
        else $error("request accepted with two results pending");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(pixel_out)))
        else $error("stalled result changed");

endmodule

bind rect_copy_swap_blitter_top rcsb_checker u_chk (.*);
